/* hw/rtl/ps2ki_pkg.sv */
// Shared types and constants for the PS/2 keyboard start-up sequencer.
// No dependencies; imported by ps2ki_step and ps2_keyboard_init_sequencer.
package ps2ki_pkg;

   // Sequencer states, encoded as reported on rsp_init_state
   typedef enum logic [2:0] {
      ST_OFF       = 3'd0,
      ST_BAT       = 3'd1,
      ST_SET_LEDS  = 3'd2,
      ST_LEDS_ACK  = 3'd3,
      ST_READY     = 3'd4,
      ST_RESET     = 3'd5,
      ST_RESET_ACK = 3'd6
   } seq_state_type;

   // Configuration register indexes
   localparam logic CSR_WD_RELOAD = 1'b0;
   localparam logic CSR_LED_VALUE = 1'b1;

   // Reset values of the configuration registers
   localparam logic [7:0] WD_RELOAD_RESET = 8'hff;
   localparam logic [2:0] LED_VALUE_RESET = 3'd2;

   // Keyboard self-test codes and host command bytes
   localparam logic [7:0] BAT_PASS     = 8'haa;
   localparam logic [7:0] BAT_FAIL     = 8'hfc;
   localparam logic [7:0] CMD_SET_LEDS = 8'hed;
   localparam logic [7:0] CMD_RESET    = 8'hff;

   // One input item
   typedef struct packed {
      logic       action;
      logic       power_good;
      logic [7:0] bat_code;
      logic       cmd_ack;
   } req_item_type;

   // One result item
   typedef struct packed {
      seq_state_type init_state;
      logic          flush_rx;
      logic          send_cmd;
      logic [7:0]    cmd_byte;
      logic          has_arg;
      logic [7:0]    cmd_arg;
   } rsp_item_type;

endpackage

/* hw/rtl/ps2ki_step.sv */
// Next-state logic of the sequencer: one tick of state and watchdog update.
// Depends on ps2ki_pkg for the state type and the item structs.
module ps2ki_step
   import ps2ki_pkg::*;
(
   input  req_item_type  item,
   input  seq_state_type cur_state,
   input  logic [7:0]    cur_wd_count,
   input  logic [7:0]    wd_reload,
   input  logic [2:0]    led_value,
   output seq_state_type next_state,
   output logic [7:0]    next_wd_count,
   output rsp_item_type  result
);

   seq_state_type state_mid;
   logic [7:0]    wd_mid;
   logic          counting;
   logic [7:0]    wd_dec;
   rsp_item_type  res_mid;

   // Decide the transition and the command strobes
   always_comb begin
      state_mid = cur_state;
      wd_mid    = cur_wd_count;
      counting  = 1'b1;
      res_mid   = '0;
      priority if (item.action) begin
         state_mid = ST_RESET;
         counting  = 1'b0;
      end else if (!item.power_good && cur_state != ST_OFF) begin
         res_mid.flush_rx = 1'b1;
         state_mid        = ST_OFF;
         wd_mid           = 8'h00;
         counting         = 1'b0;
      end else begin
         unique case (cur_state)
            ST_OFF: begin
               if (item.power_good) begin
                  state_mid = ST_BAT;
                  wd_mid    = wd_reload;
               end
            end
            ST_BAT: begin
               if (item.bat_code == BAT_PASS) begin
                  state_mid = ST_SET_LEDS;
                  wd_mid    = wd_reload;
               end else if (item.bat_code == BAT_FAIL) begin
                  state_mid = ST_RESET;
                  wd_mid    = wd_reload;
               end
            end
            ST_SET_LEDS: begin
               res_mid.send_cmd = 1'b1;
               res_mid.cmd_byte = CMD_SET_LEDS;
               res_mid.has_arg  = 1'b1;
               res_mid.cmd_arg  = {5'd0, led_value};
               state_mid        = ST_LEDS_ACK;
               wd_mid           = wd_reload;
            end
            ST_LEDS_ACK: begin
               if (item.cmd_ack) begin
                  state_mid = ST_READY;
                  wd_mid    = 8'h00;
               end
            end
            ST_RESET: begin
               res_mid.flush_rx = 1'b1;
               res_mid.send_cmd = 1'b1;
               res_mid.cmd_byte = CMD_RESET;
               state_mid        = ST_RESET_ACK;
               wd_mid           = wd_reload;
            end
            ST_RESET_ACK: begin
               if (item.cmd_ack) begin
                  state_mid = ST_BAT;
                  wd_mid    = wd_reload;
               end
            end
            default: begin
               state_mid = cur_state;
            end
         endcase
      end
   end

   // Count the watchdog down; expiry forces the reset state
   assign wd_dec = wd_mid - 8'd1;

   always_comb begin
      next_state    = state_mid;
      next_wd_count = wd_mid;
      if (counting && wd_mid != 8'h00) begin
         next_wd_count = wd_dec;
         if (wd_dec == 8'h00) begin
            next_state = ST_RESET;
         end
      end
      result            = res_mid;
      result.init_state = next_state;
   end

endmodule

/* hw/rtl/ps2_keyboard_init_sequencer.sv */
// Top level of the PS/2 keyboard start-up sequencer: input register,
// step logic, state and result registers. Depends on ps2ki_pkg, ps2ki_step.
//
// Usage:
//   Each req_ item is one tick (req_action 0) or a reset request (1) with the
//   current power, self-test byte and acknowledge. Each item yields exactly one
//   rsp_ item: the state after the tick and the command strobes for it.
//   Items are accepted when req_valid is high and req_stall is low; results
//   are taken when rsp_valid is high and rsp_stall is low.
//   An item passes the input register and then the result register before
//   rsp_valid rises. Throughput is one item per cycle while rsp_stall is low,
//   set by the combinational state and watchdog update in ps2ki_step.
//   When the receiver stalls, the result register holds and the input register
//   keeps one more item; req_stall rises only when both are full.
//   Synchronous reset empties both registers, sets the state to off, disables
//   the watchdog and restores the watchdog reload value to 255 and led_value
//   to 2.
//   Configuration is written through csr_wr_en, csr_index and csr_wdata and
//   takes effect on the next item.
module ps2_keyboard_init_sequencer
   import ps2ki_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_action,
   input  logic       req_power_good,
   input  logic [7:0] req_bat_code,
   input  logic       req_cmd_ack,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [2:0] rsp_init_state,
   output logic       rsp_flush_rx,
   output logic       rsp_send_cmd,
   output logic [7:0] rsp_cmd_byte,
   output logic       rsp_has_arg,
   output logic [7:0] rsp_cmd_arg,
   input  logic       csr_wr_en,
   input  logic       csr_index,
   input  logic [7:0] csr_wdata
);

   logic          in_valid_ff, in_valid_in;
   req_item_type  in_item_ff, in_item_in;
   logic          out_valid_ff, out_valid_in;
   rsp_item_type  out_item_ff, out_item_in;
   seq_state_type state_ff, state_in;
   logic [7:0]    wd_count_ff, wd_count_in;
   logic [7:0]    wd_reload_ff, wd_reload_in;
   logic [2:0]    led_value_ff, led_value_in;
   logic          advance;
   logic          accept;
   seq_state_type step_state;
   logic [7:0]    step_wd_count;
   rsp_item_type  step_result;

   // Move the input item on whenever the result register is free or drains
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && out_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   ps2ki_step u_step (
      .item          (in_item_ff),
      .cur_state     (state_ff),
      .cur_wd_count  (wd_count_ff),
      .wd_reload     (wd_reload_ff),
      .led_value     (led_value_ff),
      .next_state    (step_state),
      .next_wd_count (step_wd_count),
      .result        (step_result)
   );

   // Load the input register
   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (accept) begin
         in_valid_in           = 1'b1;
         in_item_in.action     = req_action;
         in_item_in.power_good = req_power_good;
         in_item_in.bat_code   = req_bat_code;
         in_item_in.cmd_ack    = req_cmd_ack;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   // Commit the step: state, watchdog and result register
   always_comb begin
      out_valid_in = out_valid_ff;
      out_item_in  = out_item_ff;
      state_in     = state_ff;
      wd_count_in  = wd_count_ff;
      if (advance) begin
         out_valid_in = 1'b1;
         out_item_in  = step_result;
         state_in     = step_state;
         wd_count_in  = step_wd_count;
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   // Write the configuration registers
   always_comb begin
      wd_reload_in = wd_reload_ff;
      led_value_in = led_value_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CSR_WD_RELOAD: wd_reload_in = csr_wdata;
            CSR_LED_VALUE: led_value_in = csr_wdata[2:0];
            default:       wd_reload_in = wd_reload_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= ST_OFF;
         wd_count_ff  <= 8'h00;
         wd_reload_ff <= WD_RELOAD_RESET;
         led_value_ff <= LED_VALUE_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
         wd_count_ff  <= wd_count_in;
         wd_reload_ff <= wd_reload_in;
         led_value_ff <= led_value_in;
      end
   end

   // Payload registers need no reset
   always_ff @(posedge clock) begin
      in_item_ff  <= in_item_in;
      out_item_ff <= out_item_in;
   end

   // Drive the result ports
   assign rsp_valid      = out_valid_ff;
   assign rsp_init_state = out_item_ff.init_state;
   assign rsp_flush_rx   = out_item_ff.flush_rx;
   assign rsp_send_cmd   = out_item_ff.send_cmd;
   assign rsp_cmd_byte   = out_item_ff.cmd_byte;
   assign rsp_has_arg    = out_item_ff.has_arg;
   assign rsp_cmd_arg    = out_item_ff.cmd_arg;

   // Off and ready never run a watchdog
   a_wd_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OFF || state_ff == ST_READY) |-> wd_count_ff == 8'h00)
      else $error("watchdog running in off or ready state");

   // A command strobe carries one of the two host commands
   a_cmd_byte: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_send_cmd) |-> (rsp_cmd_byte == CMD_SET_LEDS ||
                                       rsp_cmd_byte == CMD_RESET))
      else $error("send strobe with unknown command byte");

   // Only set-LEDs carries an argument
   a_has_arg: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_has_arg) |-> (rsp_send_cmd && rsp_cmd_byte == CMD_SET_LEDS))
      else $error("argument flagged without set-LEDs command");

   // A flush happens only when going off or when the reset command is sent
   a_flush: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_flush_rx) |-> (rsp_init_state == ST_OFF ||
                                       rsp_init_state == ST_RESET_ACK ||
                                       rsp_init_state == ST_RESET))
      else $error("flush strobe in unexpected state");

   // A stalled result stays in the output register
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && rsp_stall) |=> (out_valid_ff && $stable(out_item_ff)))
      else $error("stalled result lost or changed");

endmodule

/* tb/ps2_keyboard_init_sequencer_tb.sv */
// Self-checking testbench for ps2_keyboard_init_sequencer: a tick driver and an output
// monitor compare every result against a cycle-free model of the start-up sequencer.
// Depends on ps2ki_pkg and the sequencer RTL only.
`timescale 1ns / 1ps

module ps2_keyboard_init_sequencer_tb;
   import ps2ki_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned HOLD_CYCLES = 80;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic       req_action = 1'b0;
   logic       req_power_good = 1'b0;
   logic [7:0] req_bat_code = 8'h00;
   logic       req_cmd_ack = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [2:0] rsp_init_state;
   logic       rsp_flush_rx;
   logic       rsp_send_cmd;
   logic [7:0] rsp_cmd_byte;
   logic       rsp_has_arg;
   logic [7:0] rsp_cmd_arg;
   logic       csr_wr_en = 1'b0;
   logic       csr_index = CSR_WD_RELOAD;
   logic [7:0] csr_wdata = 8'h00;

   // Model state and configuration, tracked in step with the block
   seq_state_type seq_now = ST_OFF;
   logic [7:0]    wdog_count = 8'h00;
   logic [7:0]    wdog_reload = WD_RELOAD_RESET;
   logic [2:0]    led_arg = LED_VALUE_RESET;

   req_item_type tick_queue[$];
   rsp_item_type predicted_outputs[$];

   int unsigned sender_idle_pct = 0;
   int unsigned receiver_stall_pct = 0;
   logic        want_hold = 1'b0;
   int unsigned hold_left = 0;
   int unsigned cycle_count = 0;
   int unsigned items_accepted = 0;
   int unsigned results_seen = 0;
   int unsigned error_count = 0;
   logic [7:0]  states_seen = 8'h00;

   ps2_keyboard_init_sequencer i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_action     (req_action),
      .req_power_good (req_power_good),
      .req_bat_code   (req_bat_code),
      .req_cmd_ack    (req_cmd_ack),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_init_state (rsp_init_state),
      .rsp_flush_rx   (rsp_flush_rx),
      .rsp_send_cmd   (rsp_send_cmd),
      .rsp_cmd_byte   (rsp_cmd_byte),
      .rsp_has_arg    (rsp_has_arg),
      .rsp_cmd_arg    (rsp_cmd_arg),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Advance the sequencer model by one item and return the outputs it should show
   function automatic rsp_item_type step_sequencer(input req_item_type it);
      rsp_item_type r;
      logic         run_watchdog;
      r = '0;
      run_watchdog = 1'b1;
      if (it.action) begin
         seq_now = ST_RESET;
         run_watchdog = 1'b0;
      end else if (!it.power_good && seq_now != ST_OFF) begin
         r.flush_rx = 1'b1;
         seq_now = ST_OFF;
         wdog_count = 8'h00;
         run_watchdog = 1'b0;
      end else begin
         case (seq_now)
            ST_OFF: begin
               if (it.power_good) begin
                  seq_now = ST_BAT;
                  wdog_count = wdog_reload;
               end
            end
            ST_BAT: begin
               if (it.bat_code == BAT_PASS) begin
                  seq_now = ST_SET_LEDS;
                  wdog_count = wdog_reload;
               end else if (it.bat_code == BAT_FAIL) begin
                  seq_now = ST_RESET;
                  wdog_count = wdog_reload;
               end
            end
            ST_SET_LEDS: begin
               r.send_cmd = 1'b1;
               r.cmd_byte = CMD_SET_LEDS;
               r.has_arg = 1'b1;
               r.cmd_arg = {5'd0, led_arg};
               seq_now = ST_LEDS_ACK;
               wdog_count = wdog_reload;
            end
            ST_LEDS_ACK: begin
               if (it.cmd_ack) begin
                  seq_now = ST_READY;
                  wdog_count = 8'h00;
               end
            end
            ST_RESET: begin
               r.flush_rx = 1'b1;
               r.send_cmd = 1'b1;
               r.cmd_byte = CMD_RESET;
               seq_now = ST_RESET_ACK;
               wdog_count = wdog_reload;
            end
            ST_RESET_ACK: begin
               if (it.cmd_ack) begin
                  seq_now = ST_BAT;
                  wdog_count = wdog_reload;
               end
            end
            default: begin
            end
         endcase
      end
      // Watchdog counts down in the same tick it was armed
      if (run_watchdog && wdog_count != 8'h00) begin
         wdog_count = wdog_count - 8'd1;
         if (wdog_count == 8'h00) begin
            seq_now = ST_RESET;
         end
      end
      r.init_state = seq_now;
      return r;
   endfunction

   task automatic check_field(input string fname, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         error_count++;
         $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, fname, want, got);
      end
   endtask

   task automatic push_tick(input logic a, input logic p, input logic [7:0] b,
                            input logic k);
      req_item_type it;
      it.action = a;
      it.power_good = p;
      it.bat_code = b;
      it.cmd_ack = k;
      tick_queue.push_back(it);
   endtask

   // Biased random tick: mostly powered, frequent self-test codes and acknowledges
   task automatic push_random_tick();
      int unsigned r;
      logic [7:0]  b;
      r = $urandom_range(99);
      b = (r < 35) ? BAT_PASS : (r < 55) ? BAT_FAIL : 8'($urandom);
      push_tick($urandom_range(99) < 3, $urandom_range(99) >= 5, b,
                $urandom_range(99) < 45);
   endtask

   // Well-formed bring-up: power cycle, some noise, pass code, set-LEDs, acknowledge
   task automatic push_bringup(output int unsigned pushed);
      int unsigned waits;
      waits = $urandom_range(3);
      push_tick(1'b0, 1'b0, 8'($urandom), 1'($urandom));
      push_tick(1'b0, 1'b1, 8'($urandom), 1'($urandom));
      for (int unsigned i = 0; i < waits; i++) begin
         push_tick(1'b0, 1'b1, 8'h00, 1'($urandom));
      end
      push_tick(1'b0, 1'b1, BAT_PASS, 1'($urandom));
      push_tick(1'b0, 1'b1, 8'($urandom), 1'b0);
      push_tick(1'b0, 1'b1, 8'($urandom), 1'b1);
      pushed = 5 + waits;
   endtask

   task automatic wait_drained();
      while (tick_queue.size() != 0 || req_valid || predicted_outputs.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // Reconfigure while idle, then queue one phase of random traffic
   task automatic run_phase(input logic [7:0] arm, input logic [2:0] led,
                            input int unsigned n, input int unsigned send_pct,
                            input int unsigned stall_pct, input logic hold);
      int unsigned count;
      int unsigned got;
      wait_drained();
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_WD_RELOAD;
      csr_wdata <= arm;
      @(posedge clock);
      csr_index <= CSR_LED_VALUE;
      csr_wdata <= {5'($urandom), led};
      @(posedge clock);
      csr_wr_en <= 1'b0;
      csr_wdata <= 8'h00;
      wdog_reload = arm;
      led_arg = led;
      @(negedge clock);
      sender_idle_pct = send_pct;
      receiver_stall_pct = stall_pct;
      count = 0;
      while (count < n) begin
         if ($urandom_range(9) < 3) begin
            push_bringup(got);
            count += got;
         end else begin
            push_random_tick();
            count++;
         end
      end
      if (hold) begin
         @(posedge clock);
         want_hold <= 1'b1;
         @(posedge clock);
         want_hold <= 1'b0;
      end
   endtask

   // Offer queued items; hold the payload until it is taken
   always @(posedge clock) begin : drive_ticks
      logic         take_next;
      req_item_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         take_next = !req_valid;
         if (req_valid && !req_stall) begin
            predicted_outputs.push_back(step_sequencer({req_action, req_power_good,
                                                        req_bat_code, req_cmd_ack}));
            items_accepted++;
            take_next = 1'b1;
         end
         if (take_next) begin
            if (tick_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               nxt = tick_queue.pop_front();
               req_valid <= 1'b1;
               req_action <= nxt.action;
               req_power_good <= nxt.power_good;
               req_bat_code <= nxt.bat_code;
               req_cmd_ack <= nxt.cmd_ack;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Long receiver hold-off, counted here
   always @(posedge clock) begin : hold_receiver
      if (reset) begin
         hold_left <= 0;
      end else if (want_hold) begin
         hold_left <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Take results and compare each with the oldest prediction
   always @(posedge clock) begin : check_outputs
      rsp_item_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            states_seen[rsp_init_state] = 1'b1;
            if (predicted_outputs.size() == 0) begin
               error_count++;
               $display("%0t: result with nothing expected, state 0x%0h", $time,
                        rsp_init_state);
            end else begin
               want = predicted_outputs.pop_front();
               check_field("init_state", want.init_state, rsp_init_state);
               check_field("flush_rx", want.flush_rx, rsp_flush_rx);
               check_field("send_cmd", want.send_cmd, rsp_send_cmd);
               check_field("cmd_byte", want.cmd_byte, rsp_cmd_byte);
               check_field("has_arg", want.has_arg, rsp_has_arg);
               check_field("cmd_arg", want.cmd_arg, rsp_cmd_arg);
            end
         end
         rsp_stall <= (hold_left != 0) || ($urandom_range(99) < receiver_stall_pct);
      end
   end

   // Stop a hung run
   always @(posedge clock) begin : watch_limit
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("ps2_keyboard_init_sequencer_tb: done, errors");
         $finish;
      end
   end

   initial begin : run_test
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed walk through every state and special case, default settings
      push_tick(1'b0, 1'b0, 8'h00, 1'b0);        // unpowered in off: stay
      push_tick(1'b1, 1'b0, 8'h00, 1'b0);        // reset request from off
      push_tick(1'b0, 1'b1, 8'h00, 1'b0);        // reset: flush and send reset
      push_tick(1'b0, 1'b1, 8'h00, 1'b0);        // wait for acknowledge
      push_tick(1'b0, 1'b1, 8'hff, 1'b1);        // acknowledged: back to bat
      push_tick(1'b0, 1'b1, 8'h00, 1'b1);        // no self-test code yet
      push_tick(1'b0, 1'b1, BAT_FAIL, 1'b0);     // fail code
      push_tick(1'b0, 1'b1, 8'hff, 1'b0);
      push_tick(1'b0, 1'b1, 8'h55, 1'b1);
      push_tick(1'b0, 1'b1, BAT_PASS, 1'b0);     // pass code
      push_tick(1'b0, 1'b1, 8'hff, 1'b1);        // send set-LEDs with argument
      push_tick(1'b0, 1'b1, 8'h00, 1'b0);
      push_tick(1'b0, 1'b1, 8'h00, 1'b1);        // acknowledged: ready
      push_tick(1'b0, 1'b1, BAT_PASS, 1'b1);     // ready holds
      push_tick(1'b0, 1'b0, 8'hff, 1'b1);        // power loss from ready
      push_tick(1'b0, 1'b0, BAT_PASS, 1'b1);     // power loss while off
      push_tick(1'b0, 1'b1, BAT_FAIL, 1'b0);
      push_tick(1'b0, 1'b0, 8'h00, 1'b0);        // power loss from bat
      push_tick(1'b0, 1'b1, 8'h00, 1'b0);
      push_tick(1'b1, 1'b0, 8'hff, 1'b1);        // reset request overrides power loss
      push_tick(1'b0, 1'b0, 8'h00, 1'b0);        // power loss from reset

      run_phase(8'd1, 3'd7, 150, 64, 0, 1'b0);
      run_phase(8'd0, 3'd0, 150, 0, 64, 1'b0);
      run_phase(8'd4, 3'd5, 200, 25, 25, 1'b0);
      run_phase(8'd255, 3'd7, 150, 0, 0, 1'b1);
      run_phase(8'($urandom_range(12, 2)), 3'($urandom_range(7)), 250, 0, 25, 1'b0);

      wait_drained();
      repeat (8) @(posedge clock);
      $display("covered %0d items and %0d results over six register settings",
               items_accepted, results_seen);
      $display("states reached, one bit per code: %b", states_seen);
      if (error_count == 0 && predicted_outputs.size() == 0) begin
         $display("ps2_keyboard_init_sequencer_tb: done, clean");
      end else begin
         $display("ps2_keyboard_init_sequencer_tb: done, errors");
      end
      $finish;
   end

endmodule
